// ===== sv/crc_checked_serial_frame_deframer_top_assert.svh =====
// assertion helpers shared by the deframer modules
`ifndef CRC_CHECKED_SERIAL_FRAME_DEFRAMER_TOP_ASSERT_SVH
`define CRC_CHECKED_SERIAL_FRAME_DEFRAMER_TOP_ASSERT_SVH

// same-cycle implication
`define CSFD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CSFD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/csfd_pkg.sv =====
package csfd_pkg;

   localparam int BYTE_W  = 8;
   localparam int LEN_W   = 11;
   localparam int IDX_W   = 10;
   localparam int CMD_W   = 16;
   localparam int ALEN_W  = 16;
   localparam int STAT_W  = 2;
   localparam int CSR_IDX_W = 1;

   localparam int MAX_PAYLOAD_DEF = 1024;
   localparam int LIMIT_MAX = (1 << LEN_W) - 1;

   localparam logic [BYTE_W-1:0] START_BYTE_RST    = 8'hA5;
   localparam logic [LEN_W-1:0]  PAYLOAD_LIMIT_RST = 11'd1024;
   localparam logic [7:0]        HCRC_SEED  = 8'hFF;
   localparam logic [15:0]       CRC16_INIT = 16'hFFFF;
   localparam logic [7:0]        CRC8_POLY  = 8'h8C;
   localparam logic [15:0]       CRC16_POLY = 16'h8408;

   localparam logic [CSR_IDX_W-1:0] CSR_START_BYTE    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAYLOAD_LIMIT = 1'd1;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_HDR_CRC   = 2'd1;
   localparam logic [STAT_W-1:0] ST_TOO_LONG  = 2'd2;
   localparam logic [STAT_W-1:0] ST_FRAME_CRC = 2'd3;

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_HEADER,
      PH_CMD,
      PH_PAYLOAD,
      PH_TAIL
   } phase_type;

   typedef struct packed {
      logic              valid;
      logic              kind;
      logic [BYTE_W-1:0] pbyte;
      logic [IDX_W-1:0]  index;
      logic [CMD_W-1:0]  cmd;
      logic [BYTE_W-1:0] seq;
      logic [LEN_W-1:0]  len;
      logic [STAT_W-1:0] status;
   } res_type;

   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC8_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC16_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ===== sv/csfd_core.sv =====
module csfd_core #(
   parameter int MAX_PAYLOAD = csfd_pkg::MAX_PAYLOAD_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  logic [csfd_pkg::BYTE_W-1:0]  rx_byte,
   input  logic [csfd_pkg::BYTE_W-1:0]  start_byte,
   input  logic [csfd_pkg::LEN_W-1:0]   payload_limit,
   output csfd_pkg::res_type            res
);

   localparam int CAP   = (MAX_PAYLOAD < csfd_pkg::LIMIT_MAX) ? MAX_PAYLOAD
                                                               : csfd_pkg::LIMIT_MAX;
   localparam int CNT_W = $clog2(CAP + 1);
   localparam logic [csfd_pkg::ALEN_W-1:0] MAX_LEN = csfd_pkg::ALEN_W'(MAX_PAYLOAD);

   csfd_pkg::phase_type phase_ff, phase_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic [7:0]                   hcrc_ff, hcrc_in;
   logic [15:0]                  fcrc_ff, fcrc_in;
   logic [csfd_pkg::ALEN_W-1:0]  len_ff, len_in;
   logic [csfd_pkg::CMD_W-1:0]   cmd_ff, cmd_in;
   logic [csfd_pkg::BYTE_W-1:0]  seq_ff, seq_in;
   logic [csfd_pkg::BYTE_W-1:0]  tail_ff, tail_in;

   logic [csfd_pkg::ALEN_W-1:0]  limit;
   logic [csfd_pkg::ALEN_W-1:0]  limit_ext;
   logic [CNT_W-1:0]             cnt_inc;
   logic [csfd_pkg::ALEN_W-1:0]  idx_wide;
   logic [csfd_pkg::LEN_W-1:0]   len_sat;
   logic [15:0]                  fcrc_step;
   logic                         hdr_last, hdr_bad, too_long, pay_done;

   assign limit_ext = csfd_pkg::ALEN_W'(payload_limit);
   assign limit     = (limit_ext > MAX_LEN) ? MAX_LEN : limit_ext;
   assign cnt_inc   = cnt_ff + 1'b1;
   assign idx_wide  = csfd_pkg::ALEN_W'(cnt_ff);
   assign len_sat   = (|len_ff[csfd_pkg::ALEN_W-1:csfd_pkg::LEN_W])
                      ? csfd_pkg::LEN_W'(csfd_pkg::LIMIT_MAX) : len_ff[csfd_pkg::LEN_W-1:0];
   assign fcrc_step = csfd_pkg::crc16_step(fcrc_ff, rx_byte);
   // header bytes are counted 1..4, the fourth one is the crc
   assign hdr_last  = (cnt_ff != CNT_W'(1)) && (cnt_ff != CNT_W'(2)) && (cnt_ff != CNT_W'(3));
   assign hdr_bad   = (rx_byte != hcrc_ff);
   assign too_long  = (len_ff > limit);
   assign pay_done  = (csfd_pkg::ALEN_W'(cnt_inc) >= len_ff);

   // next state
   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         case (phase_ff)
            csfd_pkg::PH_HUNT: begin
               if (rx_byte == start_byte) phase_in = csfd_pkg::PH_HEADER;
            end
            csfd_pkg::PH_HEADER: begin
               if (hdr_last) begin
                  phase_in = (hdr_bad || too_long) ? csfd_pkg::PH_HUNT : csfd_pkg::PH_CMD;
               end
            end
            csfd_pkg::PH_CMD: begin
               if (cnt_ff != '0) begin
                  phase_in = (len_ff == '0) ? csfd_pkg::PH_TAIL : csfd_pkg::PH_PAYLOAD;
               end
            end
            csfd_pkg::PH_PAYLOAD: begin
               if (pay_done) phase_in = csfd_pkg::PH_TAIL;
            end
            csfd_pkg::PH_TAIL: begin
               if (cnt_ff != '0) phase_in = csfd_pkg::PH_HUNT;
            end
            default: phase_in = csfd_pkg::PH_HUNT;
         endcase
      end
   end

   // datapath and result
   always_comb begin
      cnt_in  = cnt_ff;
      hcrc_in = hcrc_ff;
      fcrc_in = fcrc_ff;
      len_in  = len_ff;
      cmd_in  = cmd_ff;
      seq_in  = seq_ff;
      tail_in = tail_ff;
      res        = '0;
      res.seq    = seq_ff;
      res.len    = len_sat;
      if (step) begin
         case (phase_ff)
            csfd_pkg::PH_HUNT: begin
               if (rx_byte == start_byte) begin
                  hcrc_in = csfd_pkg::crc8_step(csfd_pkg::HCRC_SEED, rx_byte);
                  fcrc_in = csfd_pkg::crc16_step(csfd_pkg::CRC16_INIT, rx_byte);
                  len_in  = '0;
                  cmd_in  = '0;
                  seq_in  = '0;
                  cnt_in  = CNT_W'(1);
               end
            end
            csfd_pkg::PH_HEADER: begin
               fcrc_in = fcrc_step;
               if (hdr_last) begin
                  if (hdr_bad || too_long) begin
                     res.valid  = 1'b1;
                     res.kind   = csfd_pkg::KIND_STATUS;
                     res.status = hdr_bad ? csfd_pkg::ST_HDR_CRC : csfd_pkg::ST_TOO_LONG;
                     hcrc_in    = csfd_pkg::HCRC_SEED;
                     fcrc_in    = csfd_pkg::CRC16_INIT;
                  end
                  cnt_in = '0;
               end else begin
                  if (cnt_ff == CNT_W'(1)) begin
                     len_in = {8'h00, rx_byte};
                  end else if (cnt_ff == CNT_W'(2)) begin
                     len_in = {rx_byte, len_ff[7:0]};
                  end else begin
                     seq_in = rx_byte;
                  end
                  hcrc_in = csfd_pkg::crc8_step(hcrc_ff, rx_byte);
                  cnt_in  = cnt_inc;
               end
            end
            csfd_pkg::PH_CMD: begin
               fcrc_in = fcrc_step;
               if (cnt_ff == '0) begin
                  cmd_in = {8'h00, rx_byte};
                  cnt_in = CNT_W'(1);
               end else begin
                  cmd_in = {rx_byte, cmd_ff[7:0]};
                  cnt_in = '0;
               end
            end
            csfd_pkg::PH_PAYLOAD: begin
               fcrc_in   = fcrc_step;
               res.valid = 1'b1;
               res.kind  = csfd_pkg::KIND_PAYLOAD;
               res.pbyte = rx_byte;
               res.index = idx_wide[csfd_pkg::IDX_W-1:0];
               res.cmd   = cmd_ff;
               cnt_in    = pay_done ? '0 : cnt_inc;
            end
            csfd_pkg::PH_TAIL: begin
               if (cnt_ff == '0) begin
                  tail_in = rx_byte;
                  cnt_in  = CNT_W'(1);
               end else begin
                  res.valid  = 1'b1;
                  res.kind   = csfd_pkg::KIND_STATUS;
                  res.cmd    = cmd_ff;
                  res.status = ({rx_byte, tail_ff} == fcrc_ff) ? csfd_pkg::ST_OK
                                                              : csfd_pkg::ST_FRAME_CRC;
                  cnt_in  = '0;
                  hcrc_in = csfd_pkg::HCRC_SEED;
                  fcrc_in = csfd_pkg::CRC16_INIT;
               end
            end
            default: begin
               cnt_in  = '0;
               hcrc_in = csfd_pkg::HCRC_SEED;
               fcrc_in = csfd_pkg::CRC16_INIT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= csfd_pkg::PH_HUNT;
         cnt_ff   <= '0;
         hcrc_ff  <= csfd_pkg::HCRC_SEED;
         fcrc_ff  <= csfd_pkg::CRC16_INIT;
         len_ff   <= '0;
         cmd_ff   <= '0;
         seq_ff   <= '0;
         tail_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         hcrc_ff  <= hcrc_in;
         fcrc_ff  <= fcrc_in;
         len_ff   <= len_in;
         cmd_ff   <= cmd_in;
         seq_ff   <= seq_in;
         tail_ff  <= tail_in;
      end
   end

`include "crc_checked_serial_frame_deframer_top_assert.svh"

   `CSFD_ASSERT_NOW(a_payload_only_in_payload, res.valid && res.kind == csfd_pkg::KIND_PAYLOAD, phase_ff == csfd_pkg::PH_PAYLOAD, "payload result outside payload phase")
   `CSFD_ASSERT_NEXT(a_hunt_after_status, res.valid && res.kind == csfd_pkg::KIND_STATUS, phase_ff == csfd_pkg::PH_HUNT && cnt_ff == '0, "no return to hunt after frame status")
   `CSFD_ASSERT_NOW(a_index_below_length, phase_ff == csfd_pkg::PH_PAYLOAD, csfd_pkg::ALEN_W'(cnt_ff) < len_ff, "payload index ran past announced length")

endmodule

// ===== sv/crc_checked_serial_frame_deframer_top.sv =====
// channel | direction | ports                      | accepted when
// req     | in        | req_valid/req_stall + byte | req_valid & !req_stall
// rsp     | out       | rsp_valid/rsp_stall + item | rsp_valid & !rsp_stall
// csr     | in        | csr_write/index/data       | csr_write
//
// one byte per cycle sustained while rsp_stall is low; a result passes from its request through the
// input register, then frame state logic into the result register
// reset clears the frame state and both registers' valid flags and restores the csr defaults
// rsp_stall holds the result register; req_stall rises only when both registers are full
module crc_checked_serial_frame_deframer_top #(
   parameter int MAX_PAYLOAD = csfd_pkg::MAX_PAYLOAD_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [csfd_pkg::BYTE_W-1:0]     req_rx_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_item_kind,
   output logic [csfd_pkg::BYTE_W-1:0]     rsp_payload_byte,
   output logic [csfd_pkg::IDX_W-1:0]      rsp_payload_index,
   output logic [csfd_pkg::CMD_W-1:0]      rsp_command_id,
   output logic [csfd_pkg::BYTE_W-1:0]     rsp_sequence_number,
   output logic [csfd_pkg::LEN_W-1:0]      rsp_frame_length,
   output logic [csfd_pkg::STAT_W-1:0]     rsp_frame_status,
   output logic                            rsp_last_of_frame,
   input  logic                            csr_write,
   input  logic [csfd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [csfd_pkg::LEN_W-1:0]      csr_data
);

   logic                        in_valid_ff;
   logic [csfd_pkg::BYTE_W-1:0] in_byte_ff;
   logic                        rsp_valid_ff;
   csfd_pkg::res_type           res_ff;
   csfd_pkg::res_type           res;
   logic [csfd_pkg::BYTE_W-1:0] start_byte_ff;
   logic [csfd_pkg::LEN_W-1:0]  payload_limit_ff;
   logic                        adv, fire;

   // result register free or being drained this cycle
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && adv;
   assign req_stall = in_valid_ff && !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff    <= csfd_pkg::START_BYTE_RST;
         payload_limit_ff <= csfd_pkg::PAYLOAD_LIMIT_RST;
      end else if (csr_write) begin
         case (csr_index)
            csfd_pkg::CSR_START_BYTE:    start_byte_ff    <= csr_data[csfd_pkg::BYTE_W-1:0];
            csfd_pkg::CSR_PAYLOAD_LIMIT: payload_limit_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) in_byte_ff <= req_rx_byte;
   end

   csfd_core #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .step          (fire),
      .rx_byte       (in_byte_ff),
      .start_byte    (start_byte_ff),
      .payload_limit (payload_limit_ff),
      .res           (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= fire && res.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && res.valid) res_ff <= res;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_item_kind       = res_ff.kind;
   assign rsp_payload_byte    = res_ff.pbyte;
   assign rsp_payload_index   = res_ff.index;
   assign rsp_command_id      = res_ff.cmd;
   assign rsp_sequence_number = res_ff.seq;
   assign rsp_frame_length    = res_ff.len;
   assign rsp_frame_status    = res_ff.status;
   assign rsp_last_of_frame   = res_ff.kind;

`include "crc_checked_serial_frame_deframer_top_assert.svh"

   `CSFD_ASSERT_NEXT(a_no_result_from_nothing, !in_valid_ff && !rsp_valid_ff, !rsp_valid_ff, "result appeared with no request in flight")
   `CSFD_ASSERT_NOW(a_stall_only_when_full, req_stall, in_valid_ff && rsp_valid_ff, "request stalled with a free register")
   `CSFD_ASSERT_NEXT(a_start_byte_written, csr_write && csr_index == csfd_pkg::CSR_START_BYTE, start_byte_ff == $past(csr_data[7:0]), "start byte write lost")

endmodule
